>>> rtl/cbis_pkg.sv
// Shared types and constants for the CBOR item skipper.
`timescale 1ns / 1ps
`default_nettype none

package cbis_pkg;

	localparam int MAX_DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP
	} fsm_t;

	typedef enum logic [1:0] {
		PH_HEAD,
		PH_ARG,
		PH_PAYLOAD
	} phase_t;

	localparam logic [1:0] STAT_BUSY    = 2'd0;
	localparam logic [1:0] STAT_DONE    = 2'd1;
	localparam logic [1:0] STAT_ERROR   = 2'd2;
	localparam logic [1:0] STAT_IGNORED = 2'd3;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_INFO  = 2'd1;
	localparam logic [1:0] ERR_DEPTH = 2'd2;
	localparam logic [1:0] ERR_TRUNC = 2'd3;

	localparam logic [2:0] MAJ_UINT   = 3'd0;
	localparam logic [2:0] MAJ_NINT   = 3'd1;
	localparam logic [2:0] MAJ_BYTES  = 3'd2;
	localparam logic [2:0] MAJ_TEXT   = 3'd3;
	localparam logic [2:0] MAJ_ARRAY  = 3'd4;
	localparam logic [2:0] MAJ_MAP    = 3'd5;
	localparam logic [2:0] MAJ_TAG    = 3'd6;
	localparam logic [2:0] MAJ_SIMPLE = 3'd7;

	localparam logic [4:0] INFO_ARG_FIRST = 5'd24;
	localparam logic [4:0] INFO_RESERVED  = 5'd28;

	// One open container on the stack.
	typedef struct packed {
		logic [63:0] items_left;
		logic        pair_half;
		logic        map_flag;
	} stk_entry_t;

endpackage

`default_nettype wire

>>> rtl/cbis_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module cbis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

>>> rtl/cbor_item_skipper_core.sv
// CBOR item skipper: byte-serial parser that reports where a top-level item ends.
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------
//  in      | in_valid, in_stall | data_byte, last_byte
//  out     | out_valid, out_stall | status, nesting_depth, error_kind
//
// Each byte is accepted while the stack top is read, then executed against the RAM
// read data. Each container closed with another one still open below it adds an
// ST_POP step for the read of that entry (single read port).
// Reset clears the control state; stack RAM contents are left as they are.
// A result waiting on out_stall holds the final execute step, input stays stalled.
`timescale 1ns / 1ps
`default_nettype none

module cbor_item_skipper_core #(
	parameter int MAX_DEPTH = cbis_pkg::MAX_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      status,
	output logic [4:0]      nesting_depth,
	output logic [1:0]      error_kind
);

	import cbis_pkg::*;

	localparam int STK_DEPTH = MAX_DEPTH - 1;
	localparam int AW        = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;
	localparam int SPW       = $clog2(MAX_DEPTH);
	localparam int XW        = SPW + AW;
	localparam int EW        = $bits(stk_entry_t);

	fsm_t             state_q, state_d;
	phase_t           phase_q, phase_d;
	logic [3:0]       arg_left_q, arg_left_d;
	logic [63:0]      arg_q, arg_d;
	logic [63:0]      pay_left_q, pay_left_d;
	logic [2:0]       major_q, major_d;
	logic [SPW-1:0]   sp_q, sp_d;
	logic             err_q, err_d;
	logic [7:0]       byte_q;
	logic             last_q;

	logic             out_valid_q;
	logic [1:0]       status_q, res_status;
	logic [4:0]       depth_q, res_depth;
	logic [1:0]       kind_q, res_kind;

	stk_entry_t       top_rd;
	stk_entry_t       wr_entry;
	logic [EW-1:0]    rd_raw;
	logic             wr_req, wr_en;
	logic [AW-1:0]    wr_addr, rd_addr;

	logic             accept, out_free, final_step, commit, pop_more;
	logic             busy_state;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign busy_state = (state_q == ST_EXEC) || (state_q == ST_POP);
	assign commit   = busy_state && (!final_step || out_free);
	assign wr_en    = wr_req && commit;
	assign top_rd   = stk_entry_t'(rd_raw);

	cbis_ram #(
		.WIDTH(EW),
		.DEPTH(STK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(EW'(wr_entry)),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	// Read next entry down when a cascade goes on, else the current top.
	always_comb begin
		logic [XW-1:0] sp_x;
		logic [XW-1:0] ra_x;
		sp_x    = XW'(sp_q);
		ra_x    = pop_more ? (sp_x - XW'(2)) : (sp_x - XW'(1));
		rd_addr = ra_x[AW-1:0];
	end

	// Datapath: one byte step, or one cascade step, against the stack top.
	always_comb begin
		logic          do_head;
		logic          do_item;
		logic          do_reset;
		logic [63:0]   v;
		logic [2:0]    maj;
		logic [4:0]    info;
		logic [63:0]   items_dec;
		logic [1:0]    st;
		logic [1:0]    kind;
		logic [XW-1:0] sp_x;
		logic [XW-1:0] wa_x;
		logic [SPW+4:0] depth_x;

		do_head    = 1'b0;
		do_item    = 1'b0;
		do_reset   = 1'b0;
		v          = 64'd0;
		maj        = major_q;
		info       = byte_q[4:0];
		items_dec  = top_rd.items_left - 64'd1;
		st         = STAT_BUSY;
		kind       = ERR_NONE;
		sp_x       = XW'(sp_q);
		wa_x       = sp_x - XW'(1);
		depth_x    = '0;

		phase_d    = phase_q;
		arg_left_d = arg_left_q;
		arg_d      = arg_q;
		pay_left_d = pay_left_q;
		major_d    = major_q;
		sp_d       = sp_q;
		err_d      = err_q;
		wr_req     = 1'b0;
		wr_entry   = top_rd;
		pop_more   = 1'b0;
		final_step = 1'b1;
		res_status = STAT_BUSY;
		res_kind   = ERR_NONE;
		res_depth  = 5'd0;

		if (state_q == ST_EXEC && err_q) begin
			res_status = STAT_IGNORED;
			do_reset   = last_q;
		end else if (busy_state) begin
			if (state_q == ST_POP) begin
				do_item = 1'b1;
			end else begin
				case (phase_q)
					PH_ARG: begin
						arg_d      = {arg_q[55:0], byte_q};
						arg_left_d = arg_left_q - 4'd1;
						if (arg_left_d == 4'd0) begin
							phase_d = PH_HEAD;
							do_head = 1'b1;
							v       = arg_d;
						end
					end
					PH_PAYLOAD: begin
						pay_left_d = pay_left_q - 64'd1;
						if (pay_left_d == 64'd0) begin
							phase_d = PH_HEAD;
							do_item = 1'b1;
						end
					end
					default: begin
						maj     = byte_q[7:5];
						major_d = byte_q[7:5];
						phase_d = PH_HEAD;
						if (info >= INFO_RESERVED || maj == MAJ_TAG) begin
							kind = ERR_INFO;
						end else if (info < INFO_ARG_FIRST) begin
							do_head = 1'b1;
							v       = 64'(info);
						end else begin
							arg_left_d = 4'd1 << info[1:0];
							arg_d      = 64'd0;
							phase_d    = PH_ARG;
						end
					end
				endcase

				if (do_head) begin
					case (maj)
						MAJ_UINT, MAJ_NINT, MAJ_SIMPLE: begin
							do_item = 1'b1;
						end
						MAJ_BYTES, MAJ_TEXT: begin
							if (v == 64'd0) begin
								do_item = 1'b1;
							end else begin
								pay_left_d = v;
								phase_d    = PH_PAYLOAD;
							end
						end
						MAJ_ARRAY, MAJ_MAP: begin
							if (v == 64'd0) begin
								do_item = 1'b1;
							end else if (sp_x >= XW'(MAX_DEPTH - 1)) begin
								kind = ERR_DEPTH;
							end else begin
								wr_req              = 1'b1;
								wa_x                = sp_x;
								wr_entry.items_left = v;
								wr_entry.pair_half  = 1'b0;
								wr_entry.map_flag   = (maj == MAJ_MAP);
								sp_d                = sp_q + SPW'(1);
							end
						end
						default: begin
							kind = ERR_INFO;
						end
					endcase
				end
			end

			// Count a finished item against the open container; close it when its items run out.
			if (do_item) begin
				if (sp_q == '0) begin
					st = STAT_DONE;
				end else if (top_rd.map_flag && !top_rd.pair_half) begin
					wr_req             = 1'b1;
					wr_entry.pair_half = 1'b1;
				end else if (items_dec != 64'd0) begin
					wr_req              = 1'b1;
					wr_entry.items_left = items_dec;
					wr_entry.pair_half  = 1'b0;
				end else begin
					sp_d = sp_q - SPW'(1);
					if (sp_d == '0) begin
						st = STAT_DONE;
					end else begin
						pop_more   = 1'b1;
						final_step = 1'b0;
					end
				end
			end

			if (kind == ERR_NONE && st == STAT_BUSY && last_q && final_step) begin
				kind = ERR_TRUNC;
			end

			if (kind != ERR_NONE) begin
				res_status = STAT_ERROR;
				res_kind   = kind;
				if (last_q) begin
					do_reset = 1'b1;
				end else begin
					err_d = 1'b1;
				end
			end else begin
				res_status = st;
				depth_x    = (SPW + 5)'(sp_d);
				res_depth  = depth_x[4:0];
			end
		end

		if (do_reset) begin
			phase_d    = PH_HEAD;
			arg_left_d = 4'd0;
			arg_d      = 64'd0;
			pay_left_d = 64'd0;
			major_d    = MAJ_UINT;
			sp_d       = '0;
			err_d      = 1'b0;
		end

		wr_addr = wa_x[AW-1:0];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC, ST_POP: begin
				if (commit) begin
					state_d = final_step ? ST_IDLE : ST_POP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Handshake outputs.
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_valid = out_valid_q;
		status = status_q;
		nesting_depth = depth_q;
		error_kind = kind_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_HEAD;
			arg_left_q  <= 4'd0;
			arg_q       <= 64'd0;
			pay_left_q  <= 64'd0;
			major_q     <= MAJ_UINT;
			sp_q        <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				phase_q    <= phase_d;
				arg_left_q <= arg_left_d;
				arg_q      <= arg_d;
				pay_left_q <= pay_left_d;
				major_q    <= major_d;
				sp_q       <= sp_d;
				err_q      <= err_d;
			end
			if (commit && final_step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= data_byte;
			last_q <= last_byte;
		end
		if (commit && final_step) begin
			status_q <= res_status;
			depth_q  <= res_depth;
			kind_q   <= res_kind;
		end
	end

endmodule

`default_nettype wire

>>> tb/tb_cbor_item_skipper_core.sv
// Self-checking testbench for the CBOR item skipper core.
`timescale 1ns / 1ps

module tb_cbor_item_skipper_core;
	import cbis_pkg::*;

	localparam int DEPTH_LIM   = MAX_DEPTH_DEF;
	localparam int RUN_LIMIT   = 300000;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEM_TARGET = 400;

	typedef struct packed {
		logic [1:0] stat;
		logic [4:0] depth;
		logic [1:0] kind;
	} parse_result_t;

	typedef struct packed {
		logic [7:0]    b;
		logic          lst;
		logic [4:0]    reps;
		logic          fixed;
		parse_result_t want;
	} script_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] status;
	logic [4:0] nesting_depth;
	logic [1:0] error_kind;

	cbor_item_skipper_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.nesting_depth(nesting_depth),
		.error_kind   (error_kind)
	);

	parse_result_t pending_results [$];
	script_row_t   script [$];
	logic [7:0]    frame_q [$];
	int            mismatches = 0;
	int            cycle_count;
	bit            calm;
	bit            hold_req;

	// parser state mirrored from the block
	phase_t      parse_phase;
	logic [3:0]  arg_left;
	logic [63:0] arg_acc;
	logic [63:0] pay_left;
	logic [2:0]  cur_major;
	logic [63:0] entries_left [DEPTH_LIM-1];
	bit          second_half [DEPTH_LIM-1];
	bit          is_map [DEPTH_LIM-1];
	int unsigned open_cnt;
	bit          in_error;

	function automatic void clear_parser();
		parse_phase = PH_HEAD;
		arg_left = '0;
		arg_acc = '0;
		pay_left = '0;
		cur_major = '0;
		open_cnt = 0;
		in_error = 1'b0;
	endfunction

	// One item finished: close containers in cascade.
	function automatic logic [1:0] close_entries();
		int unsigned t;
		while (open_cnt != 0) begin
			t = open_cnt - 1;
			if (is_map[t] && !second_half[t]) begin
				second_half[t] = 1'b1;
				return STAT_BUSY;
			end
			second_half[t] = 1'b0;
			entries_left[t] = entries_left[t] - 1;
			if (entries_left[t] != 0)
				return STAT_BUSY;
			open_cnt = open_cnt - 1;
		end
		return STAT_DONE;
	endfunction

	function automatic logic [1:0] finish_head(input logic [63:0] v, inout logic [1:0] kind);
		case (cur_major)
			MAJ_UINT, MAJ_NINT, MAJ_SIMPLE: begin
				return close_entries();
			end
			MAJ_BYTES, MAJ_TEXT: begin
				if (v == 0)
					return close_entries();
				pay_left = v;
				parse_phase = PH_PAYLOAD;
				return STAT_BUSY;
			end
			MAJ_ARRAY, MAJ_MAP: begin
				if (v == 0)
					return close_entries();
				if (open_cnt + 1 >= DEPTH_LIM) begin
					kind = ERR_DEPTH;
					return STAT_BUSY;
				end
				entries_left[open_cnt] = v;
				second_half[open_cnt] = 1'b0;
				is_map[open_cnt] = (cur_major == MAJ_MAP);
				open_cnt = open_cnt + 1;
				return STAT_BUSY;
			end
			default: begin
				kind = ERR_INFO;
				return STAT_BUSY;
			end
		endcase
	endfunction

	function automatic parse_result_t parse_byte(input logic [7:0] b, input logic lst);
		parse_result_t r;
		logic [1:0]    st;
		logic [1:0]    kind;
		logic [4:0]    info;
		st = STAT_BUSY;
		kind = ERR_NONE;
		if (in_error) begin
			if (lst)
				clear_parser();
			r = '{STAT_IGNORED, 5'd0, ERR_NONE};
			return r;
		end
		if (parse_phase == PH_ARG) begin
			arg_acc = {arg_acc[55:0], b};
			arg_left = arg_left - 4'd1;
			if (arg_left == 0) begin
				parse_phase = PH_HEAD;
				st = finish_head(arg_acc, kind);
			end
		end else if (parse_phase == PH_PAYLOAD) begin
			pay_left = pay_left - 1;
			if (pay_left == 0) begin
				parse_phase = PH_HEAD;
				st = close_entries();
			end
		end else begin
			info = b[4:0];
			cur_major = b[7:5];
			parse_phase = PH_HEAD;
			if (info >= INFO_RESERVED || cur_major == MAJ_TAG) begin
				kind = ERR_INFO;
			end else if (info < INFO_ARG_FIRST) begin
				st = finish_head({59'd0, info}, kind);
			end else begin
				arg_left = 4'd1 << (info - INFO_ARG_FIRST);
				arg_acc = '0;
				parse_phase = PH_ARG;
			end
		end
		if (kind == ERR_NONE && st == STAT_BUSY && lst)
			kind = ERR_TRUNC;
		if (kind != ERR_NONE) begin
			if (lst)
				clear_parser();
			else
				in_error = 1'b1;
			r = '{STAT_ERROR, 5'd0, kind};
			return r;
		end
		r = '{st, open_cnt[4:0], ERR_NONE};
		return r;
	endfunction

	function automatic script_row_t row(input logic [7:0] b, input logic lst, input int reps,
			input logic fixed, input logic [1:0] st, input logic [1:0] kd);
		script_row_t r;
		r.b = b;
		r.lst = lst;
		r.reps = 5'(reps);
		r.fixed = fixed;
		r.want = '{st, 5'd0, kd};
		return r;
	endfunction

	// Append one byte to the frame under construction.
	function automatic void frame_add(input logic [7:0] b);
		frame_q.insert(frame_q.size(), b);
	endfunction

	// Append one expected result to the scoreboard.
	function automatic void expect_add(input parse_result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	// Append a head with the given argument; sel 0 is immediate, 1..4 take 1/2/4/8 bytes.
	function automatic void put_head(input logic [2:0] maj, input logic [63:0] v, input int sel);
		int nb;
		if (sel == 0) begin
			frame_add({maj, v[4:0]});
			return;
		end
		nb = 1 << (sel - 1);
		frame_add({maj, INFO_ARG_FIRST + 5'(sel - 1)});
		for (int i = nb - 1; i >= 0; i--)
			frame_add(v[8*i +: 8]);
	endfunction

	// Build one well-formed top-level item into frame_q.
	function automatic void build_item(input int depth_cap, input int nest_pct);
		int          open_left [$];
		int          pick;
		int          sel;
		int          n;
		logic [2:0]  maj;
		logic [63:0] v;
		open_left.insert(open_left.size(), 1);
		while (open_left.size() != 0) begin
			if (open_left[$] == 0) begin
				void'(open_left.pop_back());
				continue;
			end
			open_left[$] = open_left[$] - 1;
			pick = $urandom_range(0, 99);
			sel = $urandom_range(0, 7);
			if (sel > 4)
				sel = 0;
			if (pick < nest_pct && open_left.size() < depth_cap && frame_q.size() < 60) begin
				maj = ($urandom_range(0, 1) != 0) ? MAJ_ARRAY : MAJ_MAP;
				n = $urandom_range(0, 3);
				put_head(maj, 64'(n), sel);
				open_left.insert(open_left.size(), (maj == MAJ_MAP) ? 2 * n : n);
			end else if ($urandom_range(0, 99) < 35) begin
				maj = ($urandom_range(0, 1) != 0) ? MAJ_BYTES : MAJ_TEXT;
				n = $urandom_range(0, 5);
				put_head(maj, 64'(n), sel);
				repeat (n) frame_add(8'($urandom));
			end else begin
				case ($urandom_range(0, 2))
					0: maj = MAJ_UINT;
					1: maj = MAJ_NINT;
					default: maj = MAJ_SIMPLE;
				endcase
				if (sel == 0)
					v = 64'($urandom_range(0, 23));
				else
					v = {$urandom, $urandom} >> (64 - 8 * (1 << (sel - 1)));
				put_head(maj, v, sel);
			end
		end
	endfunction

	task automatic log_mismatch(input string msg);
		if (mismatches < 40)
			$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Offer one byte, wait for the handshake, then record what should come out.
	task automatic send_byte(input logic [7:0] b, input logic lst, input logic fixed,
			input parse_result_t want, output logic ignored);
		parse_result_t calc;
		if (!calm && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= lst;
		do @(posedge clk); while (in_stall);
		calc = parse_byte(b, lst);
		expect_add(fixed ? want : calc);
		ignored = (calc.stat == STAT_IGNORED);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("cbor_item_skipper_core verification failed");
		$finish;
	end

	// Receiver side: random stalls, one long hold-off, and quiet stretches.
	initial begin
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 14);
			end
		end
	end

	always @(posedge clk) begin
		parse_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				log_mismatch($sformatf("result with nothing outstanding, status %0d", status));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.stat)
					log_mismatch($sformatf("status %0d, want %0d", status, want.stat));
				if (nesting_depth !== want.depth)
					log_mismatch($sformatf("nesting_depth %0d, want %0d",
						nesting_depth, want.depth));
				if (error_kind !== want.kind)
					log_mismatch($sformatf("error_kind %0d, want %0d", error_kind, want.kind));
			end
		end
	end

	initial begin
		int   mode;
		int   pos;
		int   random_count;
		logic lst;
		logic skipped;
		logic end_last;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		calm = 1'b0;
		hold_req = 1'b0;
		random_count = 0;
		clear_parser();

		script = '{
			row(8'h00, 1'b0, 1, 1'b1, STAT_DONE, ERR_NONE),
			row(8'h17, 1'b0, 1, 1'b1, STAT_DONE, ERR_NONE),
			row(8'h1B, 1'b0, 1, 1'b0, STAT_BUSY, ERR_NONE),
			row(8'hFF, 1'b0, 8, 1'b0, STAT_BUSY, ERR_NONE),
			row(8'h19, 1'b0, 1, 1'b0, STAT_BUSY, ERR_NONE),
			row(8'h12, 1'b0, 1, 1'b0, STAT_BUSY, ERR_NONE),
			row(8'h34, 1'b0, 1, 1'b0, STAT_BUSY, ERR_NONE),
			row(8'h82, 1'b0, 1, 1'b0, STAT_BUSY, ERR_NONE),
			row(8'hA1, 1'b0, 1, 1'b0, STAT_BUSY, ERR_NONE),
			row(8'h43, 1'b0, 1, 1'b0, STAT_BUSY, ERR_NONE),
			row(8'hAA, 1'b0, 3, 1'b0, STAT_BUSY, ERR_NONE),
			row(8'h60, 1'b0, 1, 1'b0, STAT_BUSY, ERR_NONE),
			row(8'hF5, 1'b0, 1, 1'b0, STAT_BUSY, ERR_NONE),
			row(8'hC0, 1'b0, 1, 1'b1, STAT_ERROR, ERR_INFO),
			row(8'h55, 1'b0, 1, 1'b1, STAT_IGNORED, ERR_NONE),
			row(8'h00, 1'b1, 1, 1'b1, STAT_IGNORED, ERR_NONE),
			row(8'hFF, 1'b0, 1, 1'b1, STAT_ERROR, ERR_INFO),
			row(8'h00, 1'b1, 1, 1'b1, STAT_IGNORED, ERR_NONE),
			row(8'h81, 1'b0, 15, 1'b0, STAT_BUSY, ERR_NONE),
			row(8'h81, 1'b0, 1, 1'b1, STAT_ERROR, ERR_DEPTH),
			row(8'h80, 1'b1, 1, 1'b1, STAT_IGNORED, ERR_NONE),
			row(8'h81, 1'b1, 1, 1'b1, STAT_ERROR, ERR_TRUNC),
			row(8'h20, 1'b1, 1, 1'b1, STAT_DONE, ERR_NONE),
			row(8'h5F, 1'b0, 1, 1'b1, STAT_ERROR, ERR_INFO),
			row(8'h00, 1'b1, 1, 1'b1, STAT_IGNORED, ERR_NONE),
			row(8'hC0, 1'b1, 1, 1'b1, STAT_ERROR, ERR_INFO),
			row(8'h00, 1'b0, 1, 1'b1, STAT_DONE, ERR_NONE),
			row(8'h42, 1'b0, 1, 1'b0, STAT_BUSY, ERR_NONE),
			row(8'h00, 1'b1, 1, 1'b1, STAT_ERROR, ERR_TRUNC),
			row(8'h1A, 1'b0, 1, 1'b0, STAT_BUSY, ERR_NONE),
			row(8'h00, 1'b1, 1, 1'b1, STAT_ERROR, ERR_TRUNC)
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			repeat (script[i].reps)
				send_byte(script[i].b, script[i].lst, script[i].fixed, script[i].want, skipped);

		// long receiver hold-off while items keep coming
		hold_req = 1'b1;

		while (random_count < ITEM_TARGET) begin
			calm = (random_count >= 150 && random_count < 250);
			frame_q.delete();
			mode = $urandom_range(0, 99);
			end_last = 1'b1;
			if (mode < 70) begin
				build_item(5, 30);
				end_last = ($urandom_range(0, 99) < 30);
			end else if (mode < 78) begin
				build_item(DEPTH_LIM + 1, 85);
			end else if (mode < 88) begin
				// truncate: raise last partway through
				build_item(5, 30);
				pos = $urandom_range(0, frame_q.size() - 1);
				while (frame_q.size() > pos + 1)
					void'(frame_q.pop_back());
			end else if (mode < 94) begin
				// corrupt one byte with a tag or reserved head
				build_item(5, 30);
				pos = $urandom_range(0, frame_q.size() - 1);
				if ($urandom_range(0, 1) != 0)
					frame_q[pos] = {MAJ_TAG, 5'($urandom)};
				else
					frame_q[pos] = {3'($urandom), 5'($urandom_range(28, 31))};
			end else begin
				repeat ($urandom_range(1, 6)) frame_add(8'($urandom));
			end
			for (int k = 0; k < frame_q.size(); k++) begin
				lst = (k == frame_q.size() - 1) ? end_last : 1'b0;
				send_byte(frame_q[k], lst, 1'b0, '0, skipped);
				if (!skipped)
					random_count++;
			end
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatches == 0)
			$display("cbor_item_skipper_core verification clean");
		else
			$display("cbor_item_skipper_core verification failed");
		$finish;
	end

endmodule
